// ===== rtl/core/acpd_pkg.sv =====
// Shared package of the phase-cut dimmer: request/response structs, opcodes,
// fixed-point constants and the Taylor divisor tables.
// No dependencies.
package acpd_pkg;

   // fixed by the field widths of the request and response
   localparam int HALF_PERIOD_TICKS   = 1000;
   localparam int POWER_FRACTION_BITS = 16;

   localparam int OP_W    = 3;
   localparam int VALUE_W = 17;
   localparam int DUTY_W  = 10;
   localparam int CNT_W   = 10;
   localparam int CMP_W   = 11;
   localparam int POWER_W = 17;

   localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_DUTY  = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_POWER = 3'd2;
   localparam logic [OP_W-1:0] OP_START     = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP      = 3'd4;

   // search bounds 0..H, and angle numerators up to 2H-1
   localparam int SRCH_W = $clog2(HALF_PERIOD_TICKS + 1);
   localparam int NUM_W  = SRCH_W + 1;

   // angle = pi * num / (4H) in Q30, split as Q*num + (R*num)/(4H)
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = PI_Q30 / 64'd2;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] ANG_DEN     = 64'(4 * HALF_PERIOD_TICKS);
   localparam logic [63:0] THETA_Q     = PI_Q30 / ANG_DEN;
   localparam logic [63:0] THETA_R     = PI_Q30 % ANG_DEN;
   localparam int          RX_W        = $clog2(4 * HALF_PERIOD_TICKS) + NUM_W;
   localparam int          THETA_SHIFT = 40;
   localparam logic [63:0] THETA_RECIP = (64'd1 << THETA_SHIFT) / ANG_DEN;

   localparam int THETA_W = 31;
   localparam int TERM_W  = 32;
   localparam int SUM_W   = 34;
   localparam int SQ_W    = 61;
   localparam int MUL_W   = 32;

   // Taylor term divisors (2n)(2n+1) and their Q33 reciprocals; entry 0 unused
   localparam int DIV_SHIFT = 33;
   localparam logic [7:0] TAYLOR_DIV [8] = '{
      8'd1, 8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
   };
   localparam logic [31:0] TAYLOR_RECIP [8] = '{
      32'd0,
      32'((64'd1 << DIV_SHIFT) / 64'd6),
      32'((64'd1 << DIV_SHIFT) / 64'd20),
      32'((64'd1 << DIV_SHIFT) / 64'd42),
      32'((64'd1 << DIV_SHIFT) / 64'd72),
      32'((64'd1 << DIV_SHIFT) / 64'd110),
      32'((64'd1 << DIV_SHIFT) / 64'd156),
      32'((64'd1 << DIV_SHIFT) / 64'd210)
   };

   localparam int ROUND_SHIFT = 60 - POWER_FRACTION_BITS;
   localparam logic [POWER_W-1:0] POWER_ONE = POWER_W'(1 << POWER_FRACTION_BITS);

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VALUE_W-1:0] value;
      logic               zero_cross;
   } req_type;

   typedef struct packed {
      logic               gate_out;
      logic [DUTY_W-1:0]  duty_now;
      logic [POWER_W-1:0] power_now;
      logic [CNT_W-1:0]   count_now;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
   } sine_ctl_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [SQ_W-1:0] sq;
   } sine_stat_type;

endpackage

// ===== rtl/core/acpd_mul_unit.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Uses acpd_pkg for the operand width.
module acpd_mul_unit (
   input  logic                          clock,
   input  logic [acpd_pkg::MUL_W-1:0]    mul_a,
   input  logic [acpd_pkg::MUL_W-1:0]    mul_b,
   output logic [2*acpd_pkg::MUL_W-1:0]  prod
);

   logic [2*acpd_pkg::MUL_W-1:0] prod_ff;
   logic [2*acpd_pkg::MUL_W-1:0] prod_in;

   assign prod_in = (2*acpd_pkg::MUL_W)'(mul_a) * (2*acpd_pkg::MUL_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/acpd_sine_seq.sv =====
// Sequencer for sin^2(pi*num/(4H)) in Q60: Taylor series to the 15th power,
// all products and constant divisions on one shared multiplier.
// Uses acpd_pkg and acpd_mul_unit.
module acpd_sine_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  acpd_pkg::sine_ctl_type  ctl,
   output acpd_pkg::sine_stat_type stat
);

   typedef enum logic [12:0] {
      SS_IDLE = 13'b0000000000001,
      SS_RX   = 13'b0000000000010,
      SS_QX   = 13'b0000000000100,
      SS_CX   = 13'b0000000001000,
      SS_TH   = 13'b0000000010000,
      SS_TS   = 13'b0000000100000,
      SS_M1   = 13'b0000001000000,
      SS_M2   = 13'b0000010000000,
      SS_D1   = 13'b0000100000000,
      SS_D2   = 13'b0001000000000,
      SS_D3   = 13'b0010000000000,
      SS_SQ   = 13'b0100000000000,
      SS_FIN  = 13'b1000000000000
   } sine_state_type;

   sine_state_type state_ff, state_in;

   logic [acpd_pkg::NUM_W-1:0]        num_ff, num_in;
   logic [acpd_pkg::RX_W-1:0]         rx_ff, rx_in;
   logic [31:0]                       qx_ff, qx_in;
   logic [acpd_pkg::THETA_W-1:0]      theta_ff, theta_in;
   logic [acpd_pkg::TERM_W-1:0]       term_ff, term_in;
   logic signed [acpd_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [2:0]                        n_ff, n_in;

   logic [acpd_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic [2*acpd_pkg::MUL_W-1:0] prod;

   logic [acpd_pkg::RX_W-1:0]    rem_t;
   logic [32:0]                  th_sum;
   logic [acpd_pkg::THETA_W-1:0] theta_c;
   logic [31:0]                  rem_d;
   logic [31:0]                  q_d;
   logic [acpd_pkg::THETA_W-1:0] s_clamp;

   acpd_mul_unit u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // sine value clamped to [0, 1.0] before squaring
   always_comb begin
      if (sum_ff[acpd_pkg::SUM_W-1]) begin
         s_clamp = '0;
      end else if (sum_ff[acpd_pkg::SUM_W-2:0] > (acpd_pkg::SUM_W-1)'(acpd_pkg::ONE_Q30)) begin
         s_clamp = acpd_pkg::THETA_W'(acpd_pkg::ONE_Q30);
      end else begin
         s_clamp = sum_ff[acpd_pkg::THETA_W-1:0];
      end
   end

   assign rem_t   = rx_ff - prod[acpd_pkg::RX_W-1:0];
   assign th_sum  = {1'b0, prod[31:0]} + {1'b0, qx_ff};
   assign theta_c = (th_sum > 33'(acpd_pkg::HALF_PI_Q30)) ?
                    acpd_pkg::THETA_W'(acpd_pkg::HALF_PI_Q30) : th_sum[acpd_pkg::THETA_W-1:0];
   assign rem_d   = term_ff - prod[31:0];
   assign q_d     = qx_ff + 32'(rem_d >= 32'(acpd_pkg::TAYLOR_DIV[n_ff]));

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      rx_in    = rx_ff;
      qx_in    = qx_ff;
      theta_in = theta_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         SS_IDLE: begin
            if (ctl.start) begin
               num_in   = ctl.num;
               state_in = SS_RX;
            end
         end
         SS_RX: begin
            mul_a    = acpd_pkg::MUL_W'(acpd_pkg::THETA_R);
            mul_b    = acpd_pkg::MUL_W'(num_ff);
            state_in = SS_QX;
         end
         SS_QX: begin
            rx_in    = prod[acpd_pkg::RX_W-1:0];
            mul_a    = acpd_pkg::MUL_W'(prod[acpd_pkg::RX_W-1:0]);
            mul_b    = acpd_pkg::MUL_W'(acpd_pkg::THETA_RECIP);
            state_in = SS_CX;
         end
         SS_CX: begin
            // quotient estimate, low by at most one
            qx_in    = 32'(prod[acpd_pkg::THETA_SHIFT +: acpd_pkg::NUM_W]);
            mul_a    = 32'(prod[acpd_pkg::THETA_SHIFT +: acpd_pkg::NUM_W]);
            mul_b    = acpd_pkg::MUL_W'(acpd_pkg::ANG_DEN);
            state_in = SS_TH;
         end
         SS_TH: begin
            qx_in    = qx_ff + 32'(rem_t >= acpd_pkg::RX_W'(acpd_pkg::ANG_DEN));
            mul_a    = acpd_pkg::MUL_W'(acpd_pkg::THETA_Q);
            mul_b    = acpd_pkg::MUL_W'(num_ff);
            state_in = SS_TS;
         end
         SS_TS: begin
            theta_in = theta_c;
            term_in  = acpd_pkg::TERM_W'(theta_c);
            sum_in   = $signed(acpd_pkg::SUM_W'(theta_c));
            n_in     = 3'd1;
            state_in = SS_M1;
         end
         SS_M1: begin
            mul_a    = term_ff;
            mul_b    = acpd_pkg::MUL_W'(theta_ff);
            state_in = SS_M2;
         end
         SS_M2: begin
            mul_a    = prod[61:30];
            mul_b    = acpd_pkg::MUL_W'(theta_ff);
            state_in = SS_D1;
         end
         SS_D1: begin
            term_in  = prod[61:30];
            mul_a    = prod[61:30];
            mul_b    = acpd_pkg::TAYLOR_RECIP[n_ff];
            state_in = SS_D2;
         end
         SS_D2: begin
            qx_in    = 32'(prod[63:acpd_pkg::DIV_SHIFT]);
            mul_a    = 32'(prod[63:acpd_pkg::DIV_SHIFT]);
            mul_b    = 32'(acpd_pkg::TAYLOR_DIV[n_ff]);
            state_in = SS_D3;
         end
         SS_D3: begin
            term_in = q_d;
            if (n_ff[0]) begin
               sum_in = sum_ff - $signed({2'b00, q_d});
            end else begin
               sum_in = sum_ff + $signed({2'b00, q_d});
            end
            if (n_ff == 3'd7) begin
               state_in = SS_SQ;
            end else begin
               n_in     = n_ff + 3'd1;
               state_in = SS_M1;
            end
         end
         SS_SQ: begin
            mul_a    = acpd_pkg::MUL_W'(s_clamp);
            mul_b    = acpd_pkg::MUL_W'(s_clamp);
            state_in = SS_FIN;
         end
         SS_FIN: begin
            state_in = SS_IDLE;
         end
         default: begin
            state_in = SS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff   <= num_in;
      rx_ff    <= rx_in;
      qx_ff    <= qx_in;
      theta_ff <= theta_in;
      term_ff  <= term_in;
      sum_ff   <= sum_in;
      n_ff     <= n_in;
   end

   assign stat.busy = (state_ff != SS_IDLE);
   assign stat.done = (state_ff == SS_FIN);
   assign stat.sq   = prod[acpd_pkg::SQ_W-1:0];

endmodule

// ===== rtl/core/ac_phase_cut_dimmer_unit.sv =====
// Top level of the phase-cut dimmer: request decode, duty search, phase counter
// and response register. Uses acpd_pkg and acpd_sine_seq.
//
// Requests (req_valid/req_ready, req_payload) carry an operation: tick, set
// duty, set power, start or stop output. Every request gives one response
// (rsp_valid/rsp_ready, rsp_payload) with the gate level, stored duty, its
// power in Q1.16 and the phase count after the request.
// A request is taken only while the control sequencer is idle. Tick, start
// and stop go straight to the finish state, which loads the response into
// the output register as soon as that register is free.
// Set duty recomputes the power figure on the shared sine sequencer; set
// power first runs a binary search over the sine curve, about ten probes,
// then the power figure, each sine evaluation on one shared 32x32 multiplier.
// The next request is accepted while a response still waits; once that one is
// done, the block holds it until the output register is free.
// Synchronous reset: counter 0, duty 0, gate low, output released, compare
// at full half period, no response pending.
module ac_phase_cut_dimmer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  acpd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output acpd_pkg::rsp_type rsp_payload
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SRCH      = 6'b000010,
      ST_SRCH_WAIT = 6'b000100,
      ST_PWR       = 6'b001000,
      ST_PWR_WAIT  = 6'b010000,
      ST_FINISH    = 6'b100000
   } ctl_state_type;

   localparam logic [acpd_pkg::CMP_W-1:0]  H_CMP  = acpd_pkg::CMP_W'(acpd_pkg::HALF_PERIOD_TICKS);
   localparam logic [acpd_pkg::DUTY_W-1:0] H_DUTY = acpd_pkg::DUTY_W'(acpd_pkg::HALF_PERIOD_TICKS);
   localparam logic [acpd_pkg::SRCH_W-1:0] H_SRCH = acpd_pkg::SRCH_W'(acpd_pkg::HALF_PERIOD_TICKS);

   ctl_state_type state_ff, state_in;

   logic [acpd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [acpd_pkg::CMP_W-1:0]   active_ff, active_in;
   logic [acpd_pkg::CMP_W-1:0]   shadow_ff, shadow_in;
   logic [acpd_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic                         gate_ff, gate_in;
   logic                         force_ff, force_in;
   logic [acpd_pkg::POWER_W-1:0] power_ff, power_in;
   logic [acpd_pkg::SRCH_W-1:0]  lo_ff, lo_in;
   logic [acpd_pkg::SRCH_W-1:0]  hi_ff, hi_in;
   logic [acpd_pkg::SRCH_W-1:0]  mid_ff, mid_in;
   logic [acpd_pkg::POWER_FRACTION_BITS-1:0] target_ff, target_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   acpd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   acpd_pkg::sine_ctl_type  sine_ctl;
   acpd_pkg::sine_stat_type sine_stat;

   logic                         accept;
   logic                         rsp_load;
   logic [acpd_pkg::CMP_W-1:0]   cnt_plus;
   logic [acpd_pkg::CNT_W-1:0]   cnt_next;
   logic [acpd_pkg::DUTY_W-1:0]  duty_clamp;
   logic [acpd_pkg::SRCH_W:0]    mid_sum;
   logic [acpd_pkg::SRCH_W-1:0]  mid_c;
   logic [acpd_pkg::SQ_W-1:0]    target_q60;
   logic [acpd_pkg::SQ_W:0]      round_sum;
   logic [acpd_pkg::SQ_W-acpd_pkg::ROUND_SHIFT:0] power_r;

   acpd_sine_seq u_sine (
      .clock (clock),
      .reset (reset),
      .ctl   (sine_ctl),
      .stat  (sine_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_load  = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_ready);

   assign cnt_plus   = acpd_pkg::CMP_W'(cnt_ff) + acpd_pkg::CMP_W'(1);
   assign cnt_next   = (req_payload.zero_cross || cnt_plus >= H_CMP) ?
                       '0 : cnt_plus[acpd_pkg::CNT_W-1:0];
   assign duty_clamp = (req_payload.value > acpd_pkg::VALUE_W'(acpd_pkg::HALF_PERIOD_TICKS)) ?
                       H_DUTY : req_payload.value[acpd_pkg::DUTY_W-1:0];

   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff} + (acpd_pkg::SRCH_W+1)'(1);
   assign mid_c      = mid_sum[acpd_pkg::SRCH_W:1];
   assign target_q60 = acpd_pkg::SQ_W'({target_ff, {acpd_pkg::ROUND_SHIFT{1'b0}}});

   // round half up to Q1.16
   assign round_sum = {1'b0, sine_stat.sq} +
                      (acpd_pkg::SQ_W+1)'(64'd1 << (acpd_pkg::ROUND_SHIFT - 1));
   assign power_r   = round_sum[acpd_pkg::SQ_W:acpd_pkg::ROUND_SHIFT];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      shadow_in = shadow_ff;
      duty_in   = duty_ff;
      gate_in   = gate_ff;
      force_in  = force_ff;
      power_in  = power_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      target_in = target_ff;
      sine_ctl.start = 1'b0;
      sine_ctl.num   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.operation)
                  acpd_pkg::OP_TICK: begin
                     cnt_in = cnt_next;
                     if (cnt_next == '0) begin
                        // new half period: shadow compare takes effect
                        active_in = shadow_ff;
                        gate_in   = (shadow_ff == '0);
                     end else if (acpd_pkg::CMP_W'(cnt_next) == active_ff) begin
                        gate_in = 1'b1;
                     end
                     state_in = ST_FINISH;
                  end
                  acpd_pkg::OP_SET_DUTY: begin
                     duty_in   = duty_clamp;
                     shadow_in = H_CMP - acpd_pkg::CMP_W'(duty_clamp);
                     state_in  = ST_PWR;
                  end
                  acpd_pkg::OP_SET_POWER: begin
                     if (req_payload.value == '0) begin
                        duty_in   = '0;
                        shadow_in = H_CMP;
                        state_in  = ST_PWR;
                     end else if (req_payload.value >= acpd_pkg::VALUE_W'(acpd_pkg::POWER_ONE)) begin
                        duty_in   = H_DUTY;
                        shadow_in = '0;
                        state_in  = ST_PWR;
                     end else begin
                        lo_in     = '0;
                        hi_in     = H_SRCH;
                        target_in = req_payload.value[acpd_pkg::POWER_FRACTION_BITS-1:0];
                        state_in  = ST_SRCH;
                     end
                  end
                  acpd_pkg::OP_START: begin
                     force_in = 1'b0;
                     state_in = ST_FINISH;
                  end
                  acpd_pkg::OP_STOP: begin
                     force_in = 1'b1;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in         = mid_c;
               sine_ctl.start = 1'b1;
               sine_ctl.num   = acpd_pkg::NUM_W'({mid_c, 1'b0} - (acpd_pkg::SRCH_W+1)'(1));
               state_in       = ST_SRCH_WAIT;
            end else begin
               duty_in   = acpd_pkg::DUTY_W'(lo_ff);
               shadow_in = H_CMP - acpd_pkg::CMP_W'(lo_ff);
               state_in  = ST_PWR;
            end
         end
         ST_SRCH_WAIT: begin
            if (sine_stat.done) begin
               if (sine_stat.sq <= target_q60) begin
                  lo_in = mid_ff;
               end else begin
                  hi_in = mid_ff - acpd_pkg::SRCH_W'(1);
               end
               state_in = ST_SRCH;
            end
         end
         ST_PWR: begin
            if (duty_ff == '0) begin
               power_in = '0;
               state_in = ST_FINISH;
            end else if (duty_ff >= H_DUTY) begin
               power_in = acpd_pkg::POWER_ONE;
               state_in = ST_FINISH;
            end else begin
               sine_ctl.start = 1'b1;
               sine_ctl.num   = acpd_pkg::NUM_W'({duty_ff, 1'b0});
               state_in       = ST_PWR_WAIT;
            end
         end
         ST_PWR_WAIT: begin
            if (sine_stat.done) begin
               if (power_r > (acpd_pkg::SQ_W-acpd_pkg::ROUND_SHIFT+1)'(acpd_pkg::POWER_ONE)) begin
                  power_in = acpd_pkg::POWER_ONE;
               end else begin
                  power_in = power_r[acpd_pkg::POWER_W-1:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in           = rsp_data_ff;
      rsp_valid_in          = rsp_valid_ff & ~rsp_ready;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.gate_out  = gate_ff & ~force_ff;
         rsp_data_in.duty_now  = duty_ff;
         rsp_data_in.power_now = power_ff;
         rsp_data_in.count_now = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= H_CMP;
         shadow_ff    <= H_CMP;
         duty_ff      <= '0;
         gate_ff      <= 1'b0;
         force_ff     <= 1'b0;
         power_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         shadow_ff    <= shadow_in;
         duty_ff      <= duty_in;
         gate_ff      <= gate_in;
         force_ff     <= force_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   a_idle_sine_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !sine_stat.busy)
      else $error("sine sequencer busy while control is idle");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      sine_stat.done |-> (state_ff == ST_SRCH_WAIT || state_ff == ST_PWR_WAIT))
      else $error("sine result with no one waiting for it");

   a_shadow_tracks_duty: assert property (@(posedge clock) disable iff (reset)
      (acpd_pkg::CMP_W'(duty_ff) + shadow_ff) == H_CMP)
      else $error("shadow compare out of step with duty");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response loaded outside finish state");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_WAIT) |-> (mid_ff > lo_ff && mid_ff <= hi_ff))
      else $error("search probe outside bounds");
`endif

endmodule
